/* rtl/core/fpc_pkg.sv */
// Shared types and constants of the float precision converter.
`timescale 1ns / 1ps
package fpc_pkg;

    // Direction codes
    localparam logic [2:0] OP_S2D = 3'd0;
    localparam logic [2:0] OP_S2Q = 3'd1;
    localparam logic [2:0] OP_D2Q = 3'd2;
    localparam logic [2:0] OP_D2S = 3'd3;
    localparam logic [2:0] OP_Q2S = 3'd4;
    localparam logic [2:0] OP_Q2D = 3'd5;

    // Destination format codes
    localparam logic [1:0] DST_NONE = 2'd0;
    localparam logic [1:0] DST_S    = 2'd1;
    localparam logic [1:0] DST_D    = 2'd2;
    localparam logic [1:0] DST_Q    = 2'd3;

    // Bias differences between formats
    localparam logic [14:0] BD_SD = 15'd896;
    localparam logic [14:0] BD_SQ = 15'd16256;
    localparam logic [14:0] BD_DQ = 15'd15360;

    localparam logic [14:0] EMAX_S = 15'd255;
    localparam logic [14:0] EMAX_D = 15'd2047;
    localparam logic [14:0] EMAX_Q = 15'd32767;

    localparam logic [16:0] FD_S = 17'd23;
    localparam logic [16:0] FD_D = 17'd52;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
    } t_fpc_in;

    typedef struct packed {
        logic [63:0] res_hi;
        logic [63:0] res_lo;
    } t_fpc_out;

    // After unpack: fraction left-aligned to 112 bits
    typedef struct packed {
        logic         sign;
        logic [2:0]   op;
        logic         emax;
        logic         ezero;
        logic         fnz;
        logic [14:0]  exp;
        logic [111:0] frac;
    } t_fpc_s1;

    // After classify: vector to shift, then extract fraction from bit 111 down
    typedef struct packed {
        logic         sign;
        logic [1:0]   dst;
        logic         left;
        logic [5:0]   amt;
        logic [14:0]  exp;
        logic [112:0] vec;
    } t_fpc_s2;

endpackage

/* rtl/core/fpc_unpack.sv */
// Stage 1: field extraction and fraction alignment.
`timescale 1ns / 1ps
module fpc_unpack
    import fpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_fpc_in i_data,
    output logic    o_valid,
    output t_fpc_s1 o_data
);

    logic    r_valid;
    t_fpc_s1 r_data;
    t_fpc_s1 n_data;

    always_comb begin
        n_data      = '0;
        n_data.op   = i_data.op;
        unique case (i_data.op) inside
            OP_S2D, OP_S2Q: begin
                n_data.sign = i_data.src_lo[31];
                n_data.exp  = {7'd0, i_data.src_lo[30:23]};
                n_data.frac = {i_data.src_lo[22:0], 89'd0};
            end
            OP_D2Q, OP_D2S: begin
                n_data.sign = i_data.src_lo[63];
                n_data.exp  = {4'd0, i_data.src_lo[62:52]};
                n_data.frac = {i_data.src_lo[51:0], 60'd0};
            end
            OP_Q2S, OP_Q2D: begin
                n_data.sign = i_data.src_hi[63];
                n_data.exp  = i_data.src_hi[62:48];
                n_data.frac = {i_data.src_hi[47:0], i_data.src_lo};
            end
            default: ;
        endcase
        // emax against source width
        unique case (i_data.op) inside
            OP_S2D, OP_S2Q: n_data.emax = (n_data.exp == EMAX_S);
            OP_D2Q, OP_D2S: n_data.emax = (n_data.exp == EMAX_D);
            default:        n_data.emax = (n_data.exp == EMAX_Q);
        endcase
        n_data.ezero = (n_data.exp == 15'd0);
        n_data.fnz   = |n_data.frac;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/core/fpc_classify.sv */
// Stage 2: special cases, exponent rebias, leading-zero count and shift plan.
`timescale 1ns / 1ps
module fpc_classify
    import fpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_fpc_s1 i_data,
    output logic    o_valid,
    output t_fpc_s2 o_data
);

    logic               r_valid;
    t_fpc_s2            r_data;
    t_fpc_s2            n_data;
    logic [5:0]         lz;
    logic [5:0]         k;
    logic [14:0]        bd;
    logic [14:0]        dmax;
    logic [16:0]        fd;
    logic signed [16:0] x;
    logic [16:0]        n;
    logic               widen;

    // leading zeros of the 52-bit aligned widening fraction
    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (i_data.frac[60 + i]) begin
                lz = 6'(51 - i);
            end
        end
    end

    always_comb begin
        widen = 1'b1;
        bd    = BD_SD;
        dmax  = EMAX_D;
        fd    = FD_D;
        n_data      = '0;
        n_data.sign = i_data.sign;
        unique case (i_data.op)
            OP_S2D: begin bd = BD_SD; dmax = EMAX_D; n_data.dst = DST_D; end
            OP_S2Q: begin bd = BD_SQ; dmax = EMAX_Q; n_data.dst = DST_Q; end
            OP_D2Q: begin bd = BD_DQ; dmax = EMAX_Q; n_data.dst = DST_Q; end
            OP_D2S: begin
                widen = 1'b0; bd = BD_SD; dmax = EMAX_S; fd = FD_S; n_data.dst = DST_S;
            end
            OP_Q2S: begin
                widen = 1'b0; bd = BD_SQ; dmax = EMAX_S; fd = FD_S; n_data.dst = DST_S;
            end
            OP_Q2D: begin
                widen = 1'b0; bd = BD_DQ; dmax = EMAX_D; fd = FD_D; n_data.dst = DST_D;
            end
            default: n_data.dst = DST_NONE;
        endcase

        k = lz + 6'd1;
        x = $signed({2'b00, i_data.exp}) - $signed({2'b00, bd});
        n = 17'(-x);

        if (widen) begin
            n_data.left = 1'b1;
            n_data.vec  = {1'b0, i_data.frac};
            if (i_data.emax) begin
                n_data.exp = dmax;
            end else if (i_data.ezero) begin
                if (i_data.fnz) begin
                    // subnormal source: normalise
                    n_data.amt = k;
                    n_data.exp = bd + 15'd1 - {9'd0, k};
                end
            end else begin
                n_data.exp = i_data.exp + bd;
            end
        end else begin
            n_data.left = 1'b0;
            if (i_data.emax) begin
                n_data.exp = dmax;
                if (i_data.fnz) begin
                    if (i_data.frac[111]) begin
                        // quiet NaN: fraction one
                        if (fd == FD_S) n_data.vec[89] = 1'b1;
                        else            n_data.vec[60] = 1'b1;
                    end else begin
                        n_data.vec[111] = 1'b1;
                    end
                end
            end else if (x >= $signed({2'b00, dmax})) begin
                n_data.exp = dmax;
            end else if (x <= 17'sd0) begin
                if (n <= fd) begin
                    n_data.vec = {1'b1, i_data.frac};
                    n_data.amt = 6'(n + 17'd1);
                end
            end else begin
                n_data.exp = x[14:0];
                n_data.vec = {1'b1, i_data.frac};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/core/fpc_pack.sv */
// Stage 3: fraction shift and result assembly into the output register.
`timescale 1ns / 1ps
module fpc_pack
    import fpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_fpc_s2  i_data,
    output logic     o_valid,
    output t_fpc_out o_data
);

    logic         r_valid;
    t_fpc_out     r_data;
    t_fpc_out     n_data;
    logic [112:0] sh;

    always_comb begin
        if (i_data.left) sh = i_data.vec << i_data.amt;
        else             sh = i_data.vec >> i_data.amt;
        n_data = '0;
        unique case (i_data.dst)
            DST_S: n_data.res_lo = {32'd0, i_data.sign, i_data.exp[7:0], sh[111:89]};
            DST_D: n_data.res_lo = {i_data.sign, i_data.exp[10:0], sh[111:60]};
            DST_Q: begin
                n_data.res_hi = {i_data.sign, i_data.exp, sh[111:64]};
                n_data.res_lo = sh[63:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/core/float_precision_convert.sv */
// Top level of the IEEE binary32/64/128 precision converter.
//
// Input channel: i_valid / o_stall carry one beat of op, src_hi, src_lo.
// Output channel: o_valid / i_stall carry one beat of res_hi, res_lo.
// A beat moves on a rising edge with valid high and stall low.
// Six directions: widening is exact (subnormals normalised by a
// leading-zero count), narrowing truncates; unused op codes give zero.
// Pipeline: three register stages (unpack, classify, shift and pack);
// a beat passes through them in that order, and o_valid is the valid
// bit of the pack stage. Each stage has its own valid bit.
// Throughput: one beat per cycle while the output beat is not stalled.
// Stall: the whole pipe holds when the output beat is stalled; holes
// in the pipe do not fill while the output waits, so o_stall equals
// "output register full and stalled". Nothing is lost or repeated.
// Reset (synchronous, active low) clears the valid bits only.
`timescale 1ns / 1ps
module float_precision_convert
    import fpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_fpc_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_fpc_out o_data
);

    logic    en;
    logic    v1;
    logic    v2;
    t_fpc_s1 d1;
    t_fpc_s2 d2;

    // pipe advances unless the result beat is held by the receiver
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    fpc_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (v1),
        .o_data  (d1)
    );

    fpc_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1),
        .i_data  (d1),
        .o_valid (v2),
        .o_data  (d2)
    );

    fpc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_data  (d2),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

/* verif/tb_float_precision_convert.sv */
// Self-checking testbench of the float precision converter.
`timescale 1ns / 1ps

// Expected results of accepted conversions, oldest first.
class conv_scoreboard;
    fpc_pkg::t_fpc_out pending[$];
    int unsigned errors;
    int unsigned checked;

    function void note(fpc_pkg::t_fpc_out exp_res);
        pending.push_back(exp_res);
    endfunction

    // One line per mismatch, counted.
    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task check(fpc_pkg::t_fpc_out got);
        fpc_pkg::t_fpc_out want;
        if (pending.size() == 0) begin
            report($sformatf("result with nothing expected hi=%h lo=%h",
                             got.res_hi, got.res_lo));
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.res_hi !== want.res_hi) begin
            report($sformatf("res_hi got %h want %h", got.res_hi, want.res_hi));
        end
        if (got.res_lo !== want.res_lo) begin
            report($sformatf("res_lo got %h want %h", got.res_lo, want.res_lo));
        end
    endtask
endclass

module tb_float_precision_convert;
    import fpc_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_fpc_in  i_data;
    logic     o_valid;
    logic     i_stall;
    t_fpc_out o_data;

    float_precision_convert uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    conv_scoreboard sb;
    int unsigned    idle_pct;    // sender gap chance, per cent
    int unsigned    stall_pct;   // receiver stall chance, per cent
    int unsigned    op_seen[8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: widening of a binary32/64 value.
    // fs/es source fraction and exponent widths, fd/ed destination.
    // ------------------------------------------------------------------
    function automatic t_fpc_out widen_value(logic sgn, logic [14:0] e, logic [51:0] f,
                                             int fs, int es, int fd, int ed);
        t_fpc_out     r;
        logic [14:0]  smax, dmax, sbias, dbias, eo;
        logic [127:0] fw;
        logic [51:0]  fn;
        int           p, k;
        smax  = (15'd1 << es) - 15'd1;
        dmax  = (15'd1 << ed) - 15'd1;
        sbias = (15'd1 << (es - 1)) - 15'd1;
        dbias = (15'd1 << (ed - 1)) - 15'd1;
        fw = '0;
        if (e == smax) begin
            eo = dmax;
            fw = 128'(f) << (fd - fs);
        end else if (e == 0) begin
            if (f == 0) begin
                eo = '0;
            end else begin
                // leading-one search normalises a subnormal
                p = fs - 1;
                while (p > 0 && f[p] == 1'b0) p--;
                k = fs - p;
                eo = dbias - sbias + 15'd1 - 15'(k);
                fn = (f << k) & ((52'd1 << fs) - 52'd1);
                fw = 128'(fn) << (fd - fs);
            end
        end else begin
            eo = e + dbias - sbias;
            fw = 128'(f) << (fd - fs);
        end
        if (ed == 11) begin
            r.res_hi = '0;
            r.res_lo = {sgn, eo[10:0], fw[51:0]};
        end else begin
            r.res_hi = {sgn, eo, fw[111:64]};
            r.res_lo = fw[63:0];
        end
        return r;
    endfunction

    // Narrowing with truncation; returns the packed destination pattern.
    function automatic logic [63:0] narrow_value(logic sgn, logic [14:0] e,
                                                 logic [111:0] f, int fs, int es,
                                                 int fd, int ed);
        logic [14:0]  smax;
        logic [63:0]  eo, fo, dmask;
        logic [112:0] sig;
        int           sbias, dbias, dmax, x, n;
        smax  = (15'd1 << es) - 15'd1;
        dmax  = (1 << ed) - 1;
        sbias = (1 << (es - 1)) - 1;
        dbias = (1 << (ed - 1)) - 1;
        dmask = (64'd1 << fd) - 64'd1;
        if (e == smax) begin
            eo = 64'(dmax);
            if (f == 0)           fo = '0;
            else if (f[fs - 1])   fo = 64'h1;            // quiet NaN
            else                  fo = 64'd1 << (fd - 1); // signalling NaN
        end else begin
            x = int'(e) - sbias + dbias;
            if (x >= dmax) begin
                eo = 64'(dmax);
                fo = '0;
            end else if (x <= 0) begin
                n  = -x;
                eo = '0;
                if (n > fd) begin
                    fo = '0;
                end else begin
                    sig = 113'(f) | (113'd1 << fs);
                    sig = sig >> (fs - fd + 1 + n);
                    fo  = sig[63:0] & dmask;
                end
            end else begin
                eo  = 64'(x);
                sig = 113'(f) >> (fs - fd);
                fo  = sig[63:0] & dmask;
            end
        end
        return (64'(sgn) << (ed + fd)) | (eo << fd) | fo;
    endfunction

    function automatic t_fpc_out convert_value(t_fpc_in d);
        t_fpc_out r;
        logic [31:0] w;
        w = d.src_lo[31:0];
        r = '0;
        case (d.op)
            OP_S2D: r = widen_value(w[31], 15'(w[30:23]), 52'(w[22:0]), 23, 8, 52, 11);
            OP_S2Q: r = widen_value(w[31], 15'(w[30:23]), 52'(w[22:0]), 23, 8, 112, 15);
            OP_D2Q: r = widen_value(d.src_lo[63], 15'(d.src_lo[62:52]),
                                    d.src_lo[51:0], 52, 11, 112, 15);
            OP_D2S: r.res_lo = narrow_value(d.src_lo[63], 15'(d.src_lo[62:52]),
                                            112'(d.src_lo[51:0]), 52, 11, 23, 8);
            OP_Q2S: r.res_lo = narrow_value(d.src_hi[63], d.src_hi[62:48],
                                            {d.src_hi[47:0], d.src_lo}, 112, 15, 23, 8);
            OP_Q2D: r.res_lo = narrow_value(d.src_hi[63], d.src_hi[62:48],
                                            {d.src_hi[47:0], d.src_lo}, 112, 15, 52, 11);
            default: r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Output side: sample at rising edge, change stall at falling edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check(o_data);
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // One beat: optional gap, then hold valid until accepted.
    // Valid stays high afterwards so the next beat can follow directly.
    task automatic send_beat(t_fpc_in d);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_data  <= d;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note(convert_value(d));
        op_seen[d.op]++;
        @(negedge i_clk);
    endtask

    // Random source shaped to hit the exponent boundaries of each format.
    function automatic t_fpc_in random_item();
        t_fpc_in d;
        int      sel;
        d.op     = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                             : 3'($urandom_range(5));
        d.src_hi = {$urandom, $urandom};
        d.src_lo = {$urandom, $urandom};
        sel = $urandom_range(9);
        case (sel)
            0: begin  // zero / subnormal source
                d.src_lo[30:23] = '0; d.src_lo[62:52] = '0; d.src_hi[62:48] = '0;
                if ($urandom_range(1)) d.src_lo[22:0] = 23'(1) << $urandom_range(22);
            end
            1: begin  // infinity / NaN
                d.src_lo[30:23] = '1; d.src_lo[62:52] = '1; d.src_hi[62:48] = '1;
                if ($urandom_range(1)) begin
                    d.src_lo[51:0] = '0; d.src_lo[22:0] = '0; d.src_hi[47:0] = '0;
                    if ($urandom_range(1)) d.src_lo = 64'd0;
                end
            end
            2: d.src_lo[62:52] = 11'(896 + $urandom_range(60) - 30);     // d->s edge
            3: d.src_hi[62:48] = 15'(16256 + $urandom_range(60) - 30);   // q->s edge
            4: d.src_hi[62:48] = 15'(15360 + $urandom_range(120) - 60);  // q->d edge
            5: d.src_lo[62:52] = 11'(1151 + $urandom_range(6) - 3);      // d->s overflow
            6: d.src_hi[62:48] = 15'(16383 + 127 + $urandom_range(6) - 3);
            7: d.src_hi[62:48] = 15'(16383 + 1023 + $urandom_range(6) - 3);
            default: ;
        endcase
        return d;
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_fpc_in d;
        t_fpc_in dir[$];
        int      ph;
        sb = new();
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_data    = '0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats: zeros, ones, each op on specials, unused codes.
        for (int op = 0; op < 8; op++) begin
            dir.push_back('{op: 3'(op), src_hi: 64'h0, src_lo: 64'h0});
            dir.push_back('{op: 3'(op), src_hi: '1, src_lo: '1});
        end
        dir.push_back('{op: OP_S2D, src_hi: 0, src_lo: 64'h0000_0001});        // min subnormal
        dir.push_back('{op: OP_S2Q, src_hi: 0, src_lo: 64'h7F80_0000});        // infinity
        dir.push_back('{op: OP_D2Q, src_hi: 0, src_lo: 64'h7FF0_0000_0000_0001});
        dir.push_back('{op: OP_D2S, src_hi: 0, src_lo: 64'h7FF8_0000_0000_0000}); // quiet NaN
        dir.push_back('{op: OP_D2S, src_hi: 0, src_lo: 64'h47F0_0000_0000_0000}); // overflow
        dir.push_back('{op: OP_Q2S, src_hi: 64'h3F6A_0000_0000_0000, src_lo: 5}); // subnormal
        dir.push_back('{op: OP_Q2D, src_hi: 64'h3FFF_8000_0000_0000, src_lo: 1});
        dir.push_back('{op: OP_Q2D, src_hi: 64'h0000_0000_0000_0001, src_lo: 0});
        foreach (dir[i]) send_beat(dir[i]);
        wait_drained();

        // Random phases: no idling, idle sender, stalling receiver, both.
        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 79 : (ph == 3) ? 24 : 0;
            stall_pct = (ph == 2) ? 79 : (ph == 3) ? 24 : 0;
            for (int i = 0; i < 350; i++) begin
                if (i == 175) wait_drained();   // sender holds off until empty
                d = random_item();
                send_beat(d);
            end
        end
        idle_pct = 0;
        wait_drained();
        stall_pct = 0;
        repeat (10) @(negedge i_clk);

        $display("Covered %0d results over six directions and unused codes", sb.checked);
        $display("s2d %0d s2q %0d d2q %0d d2s %0d q2s %0d q2d %0d spare %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
                 op_seen[5], op_seen[6] + op_seen[7]);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
